[sv/dog_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dog_pkg
// Shared constants and types for the dilated occupancy grid unit.
// ----------------------------------------------------------------------------
package dog_pkg;

    localparam int GRID_MAX  = 64;
    localparam int CELL_W    = $clog2(GRID_MAX);
    localparam int GRID_W    = CELL_W + 1;
    localparam int SHARD_W   = CELL_W - 3;
    localparam int PLANE_W   = 3;
    localparam int ADDR_W    = 3 * SHARD_W + PLANE_W;
    localparam int STORE_D   = 1 << ADDR_W;
    localparam int WORD_W    = 64;
    localparam int COORD_W   = 13;
    localparam int NUM_W     = COORD_W + 1;
    localparam int FACTOR_W  = 8;
    localparam int DIL_W     = 7;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 8;
    localparam int IN_TDATA_W = 64;

    localparam logic [CFG_IDX_W-1:0] CFG_FACTOR   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DILATION = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_Z   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_Y   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_X   = 3'd4;

    typedef logic [ADDR_W-1:0] t_addr;
    typedef logic [WORD_W-1:0] t_word;
    typedef logic [NUM_W-1:0]  t_num;

endpackage

[sv/dog_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dog_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module dog_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[sv/dog_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dog_div
// Restoring divider lane, one quotient bit per cycle while i_run is high, MSB first.
// ----------------------------------------------------------------------------
module dog_div (
    input  logic                            i_clk,
    input  logic                            i_start,
    input  logic                            i_run,
    input  dog_pkg::t_num                   i_numer,
    input  logic [dog_pkg::FACTOR_W-1:0]    i_denom,
    output dog_pkg::t_num                   o_quot
);
    import dog_pkg::*;

    logic [FACTOR_W-1:0] r_rem;
    t_num                r_num;
    t_num                r_quot;
    logic [FACTOR_W-1:0] r_den;
    logic [FACTOR_W:0]   trial;
    logic                fits;

    always_comb begin
        trial = {r_rem, r_num[NUM_W-1]};
        fits  = trial >= {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= '0;
            r_num  <= i_numer;
            r_quot <= '0;
            r_den  <= i_denom;
        end else if (i_run) begin
            // remainder stays below the divisor, so it fits in FACTOR_W bits
            r_rem  <= fits ? FACTOR_W'(trial - {1'b0, r_den}) : trial[FACTOR_W-1:0];
            r_num  <= {r_num[NUM_W-2:0], 1'b0};
            r_quot <= {r_quot[NUM_W-2:0], fits};
        end
    end

    assign o_quot = r_quot;

endmodule

[sv/dilated_occupancy_grid_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dilated_occupancy_grid_unit
// Marks dilated voxel footprints in a cell bitmap and reads back plane words.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries requests: tuser selects voxel sample (0) or mask read (1).
//   m_axis returns one 64-bit plane word for each read request, in order.
//   The cfg channel writes cell_factor, dilation and grid sizes by index;
//   it is always ready and should only be used while the unit is idle.
//   After reset the unit sweeps the 4096-word store to zero, one word a
//   cycle; s_axis_tready stays low until the sweep is done.
//   One request is in flight at a time. A zero voxel leaves the unit idle.
//   A nonzero voxel runs the bit-serial span divider, a range check, then
//   a read and a write back per touched store word (1 to 12 words, none
//   when the span starts outside the grid) through the single store port.
//   A read goes through S_RRD, the registered store read, and S_RLD to the
//   output register. A result waiting on m_axis does not block voxels;
//   a following read waits until the output register has been taken.
// ----------------------------------------------------------------------------
module dilated_occupancy_grid_unit (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // voxel_z, voxel_y, voxel_x, voxel_value, shard_z, shard_y, shard_x, plane_z
    input  logic [dog_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // req_type
    input  logic                               s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // mask_word
    output logic [dog_pkg::WORD_W-1:0]         m_axis_tdata,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [dog_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [dog_pkg::CFG_DAT_W-1:0]      i_cfg_data
);
    import dog_pkg::*;

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_DIV   = 3'd2;
    localparam logic [2:0] S_CHK   = 3'd3;
    localparam logic [2:0] S_RD    = 3'd4;
    localparam logic [2:0] S_WR    = 3'd5;
    localparam logic [2:0] S_RRD   = 3'd6;
    localparam logic [2:0] S_RLD   = 3'd7;

    localparam int STEP_W = $clog2(NUM_W);

    // configuration
    logic [FACTOR_W-1:0] r_factor;
    logic [DIL_W-1:0]    r_dil;
    logic [GRID_W-1:0]   r_gz, r_gy, r_gx;

    logic [2:0]          r_state;
    logic [ADDR_W-1:0]   r_clr;
    logic [STEP_W-1:0]   r_step;
    t_addr               r_rd_addr;
    logic                r_out_valid;
    t_word               r_out_data;

    logic [CELL_W-1:0]   r_z0, r_z1, r_y0, r_y1, r_x0, r_x1;
    logic [CELL_W-1:0]   r_cz;
    logic [SHARD_W-1:0]  r_ys, r_xs;

    // input fields
    logic [COORD_W-1:0]  vz, vy, vx;
    logic [7:0]          vval;
    logic [SHARD_W-1:0]  sz, sy, sx;
    logic [PLANE_W-1:0]  pz;

    assign vz   = s_axis_tdata[12:0];
    assign vy   = s_axis_tdata[25:13];
    assign vx   = s_axis_tdata[38:26];
    assign vval = s_axis_tdata[46:39];
    assign sz   = s_axis_tdata[49:47];
    assign sy   = s_axis_tdata[52:50];
    assign sx   = s_axis_tdata[55:53];
    assign pz   = s_axis_tdata[58:56];

    logic in_acc;
    assign s_axis_tready = (r_state == S_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready   = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_factor <= FACTOR_W'(4);
            r_dil    <= '0;
            r_gz     <= GRID_W'(32);
            r_gy     <= GRID_W'(32);
            r_gx     <= GRID_W'(32);
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_FACTOR:   r_factor <= i_cfg_data;
                CFG_DILATION: r_dil    <= i_cfg_data[DIL_W-1:0];
                CFG_GRID_Z:   r_gz     <= i_cfg_data[GRID_W-1:0];
                CFG_GRID_Y:   r_gy     <= i_cfg_data[GRID_W-1:0];
                CFG_GRID_X:   r_gx     <= i_cfg_data[GRID_W-1:0];
                default: ;
            endcase
        end
    end

    // effective factor, dilation and grid sizes
    logic [FACTOR_W-1:0] f_eff, d_eff;
    logic [GRID_W-1:0]   gz_eff, gy_eff, gx_eff;
    always_comb begin
        f_eff  = (r_factor == '0) ? FACTOR_W'(1) : r_factor;
        d_eff  = ({1'b0, r_dil} >= f_eff) ? f_eff - FACTOR_W'(1) : {1'b0, r_dil};
        gz_eff = (r_gz > GRID_W'(GRID_MAX)) ? GRID_W'(GRID_MAX) : r_gz;
        gy_eff = (r_gy > GRID_W'(GRID_MAX)) ? GRID_W'(GRID_MAX) : r_gy;
        gx_eff = (r_gx > GRID_W'(GRID_MAX)) ? GRID_W'(GRID_MAX) : r_gx;
    end

    // span numerators: lo = max(c-d, 0), hi = c+d
    t_num lo_z, lo_y, lo_x, hi_z, hi_y, hi_x;
    always_comb begin
        hi_z = NUM_W'(vz) + NUM_W'(d_eff);
        hi_y = NUM_W'(vy) + NUM_W'(d_eff);
        hi_x = NUM_W'(vx) + NUM_W'(d_eff);
        lo_z = (NUM_W'(vz) < NUM_W'(d_eff)) ? '0 : NUM_W'(vz) - NUM_W'(d_eff);
        lo_y = (NUM_W'(vy) < NUM_W'(d_eff)) ? '0 : NUM_W'(vy) - NUM_W'(d_eff);
        lo_x = (NUM_W'(vx) < NUM_W'(d_eff)) ? '0 : NUM_W'(vx) - NUM_W'(d_eff);
    end

    logic div_start, div_run;
    t_num q_lz, q_ly, q_lx, q_hz, q_hy, q_hx;
    assign div_start = in_acc && !s_axis_tuser;
    assign div_run   = (r_state == S_DIV);

    dog_div u_div_lz (.i_clk(i_clk), .i_start(div_start), .i_run(div_run),
                      .i_numer(lo_z), .i_denom(f_eff), .o_quot(q_lz));
    dog_div u_div_ly (.i_clk(i_clk), .i_start(div_start), .i_run(div_run),
                      .i_numer(lo_y), .i_denom(f_eff), .o_quot(q_ly));
    dog_div u_div_lx (.i_clk(i_clk), .i_start(div_start), .i_run(div_run),
                      .i_numer(lo_x), .i_denom(f_eff), .o_quot(q_lx));
    dog_div u_div_hz (.i_clk(i_clk), .i_start(div_start), .i_run(div_run),
                      .i_numer(hi_z), .i_denom(f_eff), .o_quot(q_hz));
    dog_div u_div_hy (.i_clk(i_clk), .i_start(div_start), .i_run(div_run),
                      .i_numer(hi_y), .i_denom(f_eff), .o_quot(q_hy));
    dog_div u_div_hx (.i_clk(i_clk), .i_start(div_start), .i_run(div_run),
                      .i_numer(hi_x), .i_denom(f_eff), .o_quot(q_hx));

    // range check and clamp
    logic              skip;
    logic [CELL_W-1:0] z1c, y1c, x1c;
    always_comb begin
        skip = (q_lz >= NUM_W'(gz_eff)) || (q_ly >= NUM_W'(gy_eff)) ||
               (q_lx >= NUM_W'(gx_eff));
        z1c = (q_hz >= NUM_W'(gz_eff)) ? CELL_W'(gz_eff - GRID_W'(1)) : q_hz[CELL_W-1:0];
        y1c = (q_hy >= NUM_W'(gy_eff)) ? CELL_W'(gy_eff - GRID_W'(1)) : q_hy[CELL_W-1:0];
        x1c = (q_hx >= NUM_W'(gx_eff)) ? CELL_W'(gx_eff - GRID_W'(1)) : q_hx[CELL_W-1:0];
    end

    // bits of the current word: rows in [y0,y1] and columns in [x0,x1]
    logic [7:0] row_m, col_m;
    t_word      set_m;
    always_comb begin
        for (int r = 0; r < 8; r++) begin
            row_m[r] = ({r_ys, 3'(r)} >= r_y0) && ({r_ys, 3'(r)} <= r_y1);
            col_m[r] = ({r_xs, 3'(r)} >= r_x0) && ({r_xs, 3'(r)} <= r_x1);
        end
        for (int b = 0; b < WORD_W; b++) begin
            set_m[b] = row_m[b / 8] && col_m[b % 8];
        end
    end

    t_addr vox_addr;
    assign vox_addr = {r_cz[CELL_W-1:3], r_ys, r_xs, r_cz[2:0]};

    logic  ram_we;
    t_addr ram_waddr, ram_raddr;
    t_word ram_wdata, ram_rdata;

    always_comb begin
        ram_we    = (r_state == S_CLEAR) || (r_state == S_WR);
        ram_waddr = (r_state == S_CLEAR) ? r_clr : vox_addr;
        ram_wdata = (r_state == S_CLEAR) ? '0 : (ram_rdata | set_m);
        ram_raddr = (r_state == S_RRD) ? r_rd_addr : vox_addr;
    end

    dog_ram #(.WIDTH(WORD_W), .DEPTH(STORE_D)) u_store (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    logic x_last, y_last, z_last;
    assign x_last = (r_xs == r_x1[CELL_W-1:3]);
    assign y_last = (r_ys == r_y1[CELL_W-1:3]);
    assign z_last = (r_cz == r_z1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + ADDR_W'(1);
                    if (r_clr == ADDR_W'(STORE_D - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (in_acc) begin
                        if (s_axis_tuser) begin
                            r_state <= S_RRD;
                        end else if (vval != '0) begin
                            r_state <= S_DIV;
                            r_step  <= '0;
                        end
                    end
                end
                S_DIV: begin
                    r_step <= r_step + STEP_W'(1);
                    if (r_step == STEP_W'(NUM_W - 1)) begin
                        r_state <= S_CHK;
                    end
                end
                S_CHK: begin
                    r_state <= skip ? S_IDLE : S_RD;
                end
                S_RD: begin
                    r_state <= S_WR;
                end
                S_WR: begin
                    r_state <= (x_last && y_last && z_last) ? S_IDLE : S_RD;
                end
                S_RRD: begin
                    if (!r_out_valid || m_axis_tready) begin
                        r_state <= S_RLD;
                    end
                end
                S_RLD: begin
                    r_out_valid <= 1'b1;
                    r_state     <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_rd_addr <= {sz, sy, sx, pz};
        end
        if (r_state == S_RLD) begin
            r_out_data <= ram_rdata;
        end
        if (r_state == S_CHK) begin
            r_z0 <= q_lz[CELL_W-1:0];
            r_y0 <= q_ly[CELL_W-1:0];
            r_x0 <= q_lx[CELL_W-1:0];
            r_z1 <= z1c;
            r_y1 <= y1c;
            r_x1 <= x1c;
            r_cz <= q_lz[CELL_W-1:0];
            r_ys <= q_ly[CELL_W-1:3];
            r_xs <= q_lx[CELL_W-1:3];
        end else if (r_state == S_WR) begin
            if (!x_last) begin
                r_xs <= r_xs + SHARD_W'(1);
            end else begin
                r_xs <= r_x0[CELL_W-1:3];
                if (!y_last) begin
                    r_ys <= r_ys + SHARD_W'(1);
                end else begin
                    r_ys <= r_y0[CELL_W-1:3];
                    r_cz <= r_cz + CELL_W'(1);
                end
            end
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

`ifndef SYNTHESIS
    a_no_accept_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> !s_axis_tready)
        else $error("input accepted during store clear");

    a_write_follows_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WR) |-> ($past(r_state) == S_RD))
        else $error("write-back without preceding store read");

    a_cz_in_span: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RD) |-> ((r_cz >= r_z0) && (r_cz <= r_z1)))
        else $error("cell z outside footprint span");

    a_load_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RLD) |-> !r_out_valid)
        else $error("output register overwritten");
`endif

endmodule

[tb/tb_dilated_occupancy_grid_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_dilated_occupancy_grid_unit
// Self-checking bench for the dilated occupancy grid unit: voxel marking under
// several factor, dilation and grid settings, with plane word reads checked
// against a bit-level predictor of the cell store, and random stream stalls.
// ----------------------------------------------------------------------------
module tb_dilated_occupancy_grid_unit;
    import dog_pkg::*;

    localparam int SHARDS   = GRID_MAX / 8;
    localparam int LIMIT    = 2_000_000;
    localparam logic REQ_VOXEL = 1'b0;
    localparam logic REQ_READ  = 1'b1;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    // voxel_z, voxel_y, voxel_x, voxel_value, shard_z, shard_y, shard_x, plane_z
    logic [IN_TDATA_W-1:0] s_axis_tdata;
    // req_type
    logic                  s_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    // mask_word
    logic [WORD_W-1:0]     m_axis_tdata;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DAT_W-1:0]  i_cfg_data;

    dilated_occupancy_grid_unit uut (.*);

    // predictor state
    logic [WORD_W-1:0] cell_words [STORE_D];
    logic [7:0]        p_factor;
    logic [6:0]        p_dilation, p_gz, p_gy, p_gx;
    logic [WORD_W-1:0] expected_words [$];

    int  cycles;
    int  fail_count;
    int  word_count;
    int  read_count;
    int  voxel_count;
    int  hold_off;
    bit  busy_phase;

    initial begin
        i_clk = 1'b0;
    end
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("status: fail");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input logic [WORD_W-1:0] got,
                                   input logic [WORD_W-1:0] want);
        $display("mismatch %s: got %h want %h", what, got, want);
        fail_count++;
    endtask

    function automatic int span_lo(int c, int f, int d);
        return (c < d ? 0 : c - d) / f;
    endfunction

    task automatic mark_cells(input int z, input int y, input int x);
        int f, d, gz, gy, gx, z0, z1, y0, y1, x0, x1, a;
        f  = (p_factor == 0) ? 1 : p_factor;
        d  = (p_dilation >= f) ? f - 1 : p_dilation;
        gz = (p_gz > GRID_MAX) ? GRID_MAX : p_gz;
        gy = (p_gy > GRID_MAX) ? GRID_MAX : p_gy;
        gx = (p_gx > GRID_MAX) ? GRID_MAX : p_gx;
        z0 = span_lo(z, f, d); z1 = (z + d) / f;
        y0 = span_lo(y, f, d); y1 = (y + d) / f;
        x0 = span_lo(x, f, d); x1 = (x + d) / f;
        if (z0 >= gz || y0 >= gy || x0 >= gx) return;
        if (z1 >= gz) z1 = gz - 1;
        if (y1 >= gy) y1 = gy - 1;
        if (x1 >= gx) x1 = gx - 1;
        for (int cz = z0; cz <= z1; cz++)
            for (int cy = y0; cy <= y1; cy++)
                for (int cx = x0; cx <= x1; cx++) begin
                    a = (((cz >> 3) * SHARDS + (cy >> 3)) * SHARDS + (cx >> 3)) * 8
                        + (cz & 7);
                    cell_words[a][(cy & 7) * 8 + (cx & 7)] = 1'b1;
                end
    endtask

    // one beat on s_axis, with bursty gaps in front
    int burst_left;
    task automatic send_beat(input logic kind, input logic [63:0] payload);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 20);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= payload;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        if (kind == REQ_VOXEL) begin
            voxel_count++;
            if (payload[46:39] != 0)
                mark_cells(int'(payload[12:0]), int'(payload[25:13]), int'(payload[38:26]));
        end else begin
            read_count++;
            expected_words.push_back(cell_words[{payload[49:47], payload[52:50],
                                                 payload[55:53], payload[58:56]}]);
        end
    endtask

    task automatic send_voxel(input int z, input int y, input int x, input int v);
        send_beat(REQ_VOXEL, {5'd0, 12'd0, 8'(v), 13'(x), 13'(y), 13'(z)});
    endtask

    task automatic send_read(input int sz, input int sy, input int sx, input int pz);
        send_beat(REQ_READ, {5'd0, 3'(pz), 3'(sx), 3'(sy), 3'(sz), 47'd0});
    endtask

    task automatic drain;
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        @(posedge i_clk);
        while (expected_words.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= 8'(val);
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            CFG_FACTOR:   p_factor   = 8'(val);
            CFG_DILATION: p_dilation = 7'(val);
            CFG_GRID_Z:   p_gz       = 7'(val);
            CFG_GRID_Y:   p_gy       = 7'(val);
            CFG_GRID_X:   p_gx       = 7'(val);
            default: ;
        endcase
    endtask

    task automatic set_all(input int f, input int d, input int gz, input int gy, input int gx);
        drain();
        write_reg(CFG_FACTOR, f);
        write_reg(CFG_DILATION, d);
        write_reg(CFG_GRID_Z, gz);
        write_reg(CFG_GRID_Y, gy);
        write_reg(CFG_GRID_X, gx);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // result checker and receiver stall pattern
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            word_count++;
            if (expected_words.size() == 0) begin
                report_mismatch("unexpected beat", m_axis_tdata, '0);
            end else begin
                if (m_axis_tdata !== expected_words[0])
                    report_mismatch("mask_word", m_axis_tdata, expected_words[0]);
                void'(expected_words.pop_front());
            end
        end
    end

    always @(posedge i_clk) begin
        if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            m_axis_tready <= 1'b0;
        end else if (busy_phase) begin
            m_axis_tready <= ($urandom_range(0, 3) != 0);
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // extremes of coordinates and value, clamping and out-of-grid skips
    task automatic test_directed;
        send_voxel(0, 0, 0, 1);
        send_voxel(8191, 8191, 8191, 255);
        send_voxel(127, 127, 127, 0);
        send_voxel(5, 9, 13, 128);
        send_voxel(4095, 2730, 5461, 1);
        send_read(0, 0, 0, 0);
        send_read(0, 0, 0, 1);
        send_read(7, 7, 7, 7);
        send_read(0, 1, 1, 1);
        send_read(5, 2, 5, 7);
        set_all(0, 127, 64, 64, 64);
        send_voxel(63, 1, 62, 7);
        send_voxel(8191, 0, 0, 2);
        send_read(7, 0, 7, 7);
        send_read(0, 0, 7, 7);
        set_all(128, 127, 1, 1, 1);
        send_voxel(300, 200, 100, 9);
        send_voxel(100, 100, 100, 9);
        send_read(0, 0, 0, 0);
        send_read(0, 0, 0, 1);
        set_all(3, 2, 0, 5, 5);
        send_voxel(3, 3, 3, 1);
        send_read(0, 0, 0, 0);
        set_all(2, 1, 127, 100, 65);
        send_voxel(126, 127, 125, 1);
        send_read(7, 7, 7, 7);
        send_read(7, 7, 7, 6);
    endtask

    task automatic random_phase(input int n);
        int lim;
        for (int i = 0; i < n; i++) begin
            lim = ($urandom_range(0, 1) != 0) ? 8191 :
                  ((p_factor == 0 ? 1 : p_factor) * 72);
            if (lim > 8191) lim = 8191;
            if ($urandom_range(0, 3) == 0)
                send_read($urandom_range(0, 7), $urandom_range(0, 7),
                          $urandom_range(0, 7), $urandom_range(0, 7));
            else
                send_voxel($urandom_range(0, lim), $urandom_range(0, lim),
                           $urandom_range(0, lim),
                           ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 255));
        end
        for (int i = 0; i < 12; i++)
            send_read($urandom_range(0, 7), $urandom_range(0, 7),
                      $urandom_range(0, 7), $urandom_range(0, 7));
    endtask

    // receiver holds off while reads pile up behind the output register
    task automatic test_backpressure;
        hold_off = 400;
        for (int i = 0; i < 20; i++)
            send_read($urandom_range(0, 3), $urandom_range(0, 3), $urandom_range(0, 3), i & 7);
        drain();
    endtask

    task automatic test_random;
        busy_phase = 1'b1;
        set_all(4, 0, 32, 32, 32);
        random_phase(150);
        set_all(1, 0, 64, 64, 64);
        random_phase(150);
        set_all(8, 3, 20, 64, 33);
        random_phase(150);
        set_all(128, 127, 64, 64, 64);
        random_phase(100);
        set_all($urandom_range(1, 16), $urandom_range(0, 20), $urandom_range(1, 127),
                $urandom_range(1, 127), $urandom_range(1, 127));
        random_phase(150);
        busy_phase = 1'b0;
        random_phase(60);
        drain();
    endtask

    initial begin
        cycles = 0; fail_count = 0; word_count = 0; read_count = 0; voxel_count = 0;
        hold_off = 0; busy_phase = 1'b0; burst_left = 0;
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0; s_axis_tdata = '0; s_axis_tuser = 1'b0;
        m_axis_tready = 1'b1;
        i_cfg_valid = 1'b0; i_cfg_index = '0; i_cfg_data = '0;
        for (int i = 0; i < STORE_D; i++) cell_words[i] = '0;
        p_factor = 8'd4; p_dilation = 7'd0; p_gz = 7'd32; p_gy = 7'd32; p_gx = 7'd32;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_backpressure();
        test_random();
        $display("covered %0d voxel beats and %0d read beats, %0d words checked",
                 voxel_count, read_count, word_count);
        $display("settings swept factor 0..128, dilation 0..127, grids 0..127");
        if (fail_count == 0 && expected_words.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
